@@ sv/qpx_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, constants and helpers for the query parameter extract/decode block.
package qpx_pkg;

   localparam int MAX_NAME   = 8;
   localparam int MAX_OUTPUT = 256;

   // Candidate vector: bit k means a segment start has matched k name characters.
   localparam int CAND_W = MAX_NAME + 1;

   // Most value bytes one input byte can produce (stale escape plus one byte).
   localparam int BUNDLE_BYTES = 3;

   // Depth of the queue between the front and back parts.
   localparam int QDEPTH  = 2;
   localparam int QPTR_W  = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
   localparam int QCNT_W  = $clog2(QDEPTH + 1);

   // Register indexes
   localparam logic [1:0] CSR_NAME_TEXT     = 2'd0;
   localparam logic [1:0] CSR_NAME_LENGTH   = 2'd1;
   localparam logic [1:0] CSR_PLUS_AS_SPACE = 2'd2;
   localparam logic [1:0] CSR_OUTPUT_CAP    = 2'd3;

   // Status codes
   localparam logic [1:0] ST_COMPLETE  = 2'd0;
   localparam logic [1:0] ST_TRUNCATED = 2'd1;
   localparam logic [1:0] ST_NOT_FOUND = 2'd2;

   // Result kinds
   localparam logic KIND_BYTE   = 1'b0;
   localparam logic KIND_STATUS = 1'b1;

   // Characters
   localparam logic [7:0] CH_PCT   = 8'h25;
   localparam logic [7:0] CH_PLUS  = 8'h2b;
   localparam logic [7:0] CH_AMP   = 8'h26;
   localparam logic [7:0] CH_EQ    = 8'h3d;
   localparam logic [7:0] CH_SPACE = 8'h20;

   typedef struct packed {
      logic [63:0] name_text;
      logic [3:0]  name_length;
      logic        plus_as_space;
      logic [8:0]  output_capacity;
   } cfg_type;

   // Everything one input byte produces: up to three value bytes and an optional status.
   typedef struct packed {
      logic [BUNDLE_BYTES-1:0][7:0] data;
      logic [1:0]                   nbytes;
      logic                         stat_en;
      logic [1:0]                   status;
   } bundle_type;

   function automatic logic is_hex(input logic [7:0] c);
      return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h66) ||
             (c >= 8'h41 && c <= 8'h46);
   endfunction

   function automatic logic [3:0] hex_val(input logic [7:0] c);
      logic [7:0] v;
      if (c >= 8'h30 && c <= 8'h39) begin
         v = c - 8'h30;
      end else if (c >= 8'h61 && c <= 8'h66) begin
         v = c - 8'h57;
      end else begin
         v = c - 8'h37;
      end
      return v[3:0];
   endfunction

endpackage

@@ sv/query_parameter_extract_decode.sv @@
`timescale 1ns / 1ps
// Top level: query parameter extraction with percent decoding.
//
//   channel  | handshake              | payload
//   ---------+------------------------+---------------------------------------------
//   req      | req_valid / req_ready  | req_in_byte, req_last_byte
//   rsp      | rsp_valid / rsp_ready  | rsp_out_kind, rsp_out_byte,
//            |                        | rsp_result_status, rsp_run_end
//   csr      | csr_write_enable       | csr_index, csr_wdata (no read-back)
//
// Cycles: the front takes one byte per cycle and handles it in that cycle;
//   the back sends one result transaction per cycle while rsp_ready is high.
//   A byte that yields k results (0 to 4) occupies the back for k transactions;
//   the two-entry bundle queue between them absorbs short bursts, so sustained
//   input rate is one byte per cycle whenever each byte yields at most one result.
// Stalls: req_ready drops only while the bundle queue is full; bytes that
//   yield no result never enter the queue.
// Reset: synchronous; no clearing pass. Registers reset to
//   empty name, form mode off, capacity 256.
module query_parameter_extract_decode import qpx_pkg::*; (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_in_byte,
   input  logic        req_last_byte,

   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_out_kind,
   output logic [7:0]  rsp_out_byte,
   output logic [1:0]  rsp_result_status,
   output logic        rsp_run_end,

   input  logic        csr_write_enable,
   input  logic [1:0]  csr_index,
   input  logic [63:0] csr_wdata
);

   cfg_type    cfg_ff, cfg_in;
   logic       accept;
   logic       push;
   logic       q_full;
   logic       q_empty;
   logic       q_pop;
   bundle_type bundle;
   bundle_type q_data;

   // configuration registers; the user must write them only between buffers, the block does not enforce it
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_NAME_TEXT:     cfg_in.name_text       = csr_wdata;
            CSR_NAME_LENGTH:   cfg_in.name_length     = csr_wdata[3:0];
            CSR_PLUS_AS_SPACE: cfg_in.plus_as_space   = csr_wdata[0];
            CSR_OUTPUT_CAP:    cfg_in.output_capacity = csr_wdata[8:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.name_text       <= '0;
         cfg_ff.name_length     <= '0;
         cfg_ff.plus_as_space   <= 1'b0;
         cfg_ff.output_capacity <= 9'(MAX_OUTPUT);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // input side only waits on queue space
   assign req_ready = !q_full;
   assign accept    = req_valid && req_ready;

   qpx_front u_front (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .accept    (accept),
      .in_byte   (req_in_byte),
      .last_byte (req_last_byte),
      .push      (push),
      .bundle    (bundle)
   );

   qpx_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .wr_data (bundle),
      .pop     (q_pop),
      .rd_data (q_data),
      .full    (q_full),
      .empty   (q_empty)
   );

   qpx_back u_back (
      .clock             (clock),
      .reset             (reset),
      .q_data            (q_data),
      .q_empty           (q_empty),
      .q_pop             (q_pop),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_out_kind      (rsp_out_kind),
      .rsp_out_byte      (rsp_out_byte),
      .rsp_result_status (rsp_result_status),
      .rsp_run_end       (rsp_run_end)
   );

endmodule

@@ sv/qpx_front.sv @@
`timescale 1ns / 1ps
// Front part: name search, percent decoding and capacity accounting per input byte.
module qpx_front import qpx_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  cfg_type    cfg,
   input  logic       accept,
   input  logic [7:0] in_byte,
   input  logic       last_byte,
   output logic       push,
   output bundle_type bundle
);

   localparam logic [1:0] PH_SEARCH = 2'd0;
   localparam logic [1:0] PH_VALUE  = 2'd1;
   localparam logic [1:0] PH_DONE   = 2'd2;

   localparam logic [1:0] ESC_NONE = 2'd0;
   localparam logic [1:0] ESC_PCT  = 2'd1;
   localparam logic [1:0] ESC_HEX  = 2'd2;

   logic [1:0]        phase_ff, phase_in;
   logic [CAND_W-1:0] cand_ff, cand_in;
   logic [1:0]        esc_ff, esc_in;
   logic [7:0]        pend_ff, pend_in;
   logic [8:0]        count_ff, count_in;
   logic              trunc_ff, trunc_in;

   logic [3:0][7:0]   cb;
   logic [1:0]        n;
   logic [3:0]        len;
   logic [CAND_W-1:0] nxt;
   logic              found;
   logic              plain;
   logic [8:0]        cap_eff;
   logic [8:0]        capm1;
   logic [8:0]        room;
   logic [8:0]        nemit;
   logic [1:0]        status;

   always_comb begin
      phase_in = phase_ff;
      cand_in  = cand_ff;
      esc_in   = esc_ff;
      pend_in  = pend_ff;
      cb       = '0;
      n        = 2'd0;
      nxt      = '0;
      found    = 1'b0;
      plain    = 1'b0;
      len      = (cfg.name_length > 4'(MAX_NAME)) ? 4'(MAX_NAME) : cfg.name_length;

      if (phase_ff == PH_SEARCH) begin
         // candidates short of the full name advance on a matching character
         for (int k = 0; k < MAX_NAME; k++) begin
            if (cand_ff[k] && (4'(k) < len) && (in_byte == cfg.name_text[8*k +: 8])) begin
               nxt[k+1] = 1'b1;
            end
         end
         // a full-length candidate followed by '=' is a hit
         found = cand_ff[len] && (in_byte == CH_EQ);
         if (found) begin
            phase_in = PH_VALUE;
            cand_in  = '0;
         end else begin
            cand_in = nxt | CAND_W'(in_byte == CH_AMP);
         end
      end else if (phase_ff == PH_VALUE) begin
         if (in_byte == CH_AMP) begin
            if (esc_in != ESC_NONE) begin
               cb[n] = CH_PCT;
               n     = n + 2'd1;
            end
            if (esc_in == ESC_HEX) begin
               cb[n] = pend_in;
               n     = n + 2'd1;
            end
            esc_in   = ESC_NONE;
            phase_in = PH_DONE;
         end else begin
            plain = 1'b1;
            if (esc_in == ESC_PCT && is_hex(in_byte)) begin
               pend_in = in_byte;
               esc_in  = ESC_HEX;
               plain   = 1'b0;
            end else if (esc_in == ESC_HEX && is_hex(in_byte)) begin
               cb[n]  = {hex_val(pend_in), hex_val(in_byte)};
               n      = n + 2'd1;
               esc_in = ESC_NONE;
               plain  = 1'b0;
            end else begin
               // stale escape goes out literally
               if (esc_in != ESC_NONE) begin
                  cb[n] = CH_PCT;
                  n     = n + 2'd1;
               end
               if (esc_in == ESC_HEX) begin
                  cb[n] = pend_in;
                  n     = n + 2'd1;
               end
               esc_in = ESC_NONE;
            end
            if (plain) begin
               if (in_byte == CH_PCT) begin
                  esc_in = ESC_PCT;
               end else if (cfg.plus_as_space && in_byte == CH_PLUS) begin
                  cb[n] = CH_SPACE;
                  n     = n + 2'd1;
               end else begin
                  cb[n] = in_byte;
                  n     = n + 2'd1;
               end
            end
         end
      end

      if (last_byte && phase_in == PH_VALUE) begin
         if (esc_in != ESC_NONE) begin
            cb[n] = CH_PCT;
            n     = n + 2'd1;
         end
         if (esc_in == ESC_HEX) begin
            cb[n] = pend_in;
            n     = n + 2'd1;
         end
         esc_in = ESC_NONE;
      end

      // capacity: zero acts as one, clamp at the maximum
      if (cfg.output_capacity == 9'd0) begin
         cap_eff = 9'd1;
      end else if (cfg.output_capacity > 9'(MAX_OUTPUT)) begin
         cap_eff = 9'(MAX_OUTPUT);
      end else begin
         cap_eff = cfg.output_capacity;
      end
      capm1    = cap_eff - 9'd1;
      room     = (count_ff < capm1) ? (capm1 - count_ff) : 9'd0;
      nemit    = (9'(n) > room) ? room : 9'(n);
      trunc_in = trunc_ff | (9'(n) > room);
      count_in = count_ff + nemit;

      if (phase_in == PH_SEARCH) begin
         status = ST_NOT_FOUND;
      end else if (trunc_in) begin
         status = ST_TRUNCATED;
      end else begin
         status = ST_COMPLETE;
      end

      if (last_byte) begin
         phase_in = PH_SEARCH;
         cand_in  = CAND_W'(1);
         esc_in   = ESC_NONE;
         pend_in  = '0;
         count_in = '0;
         trunc_in = 1'b0;
      end
   end

   assign bundle.data    = cb[BUNDLE_BYTES-1:0];
   assign bundle.nbytes  = nemit[1:0];
   assign bundle.stat_en = last_byte;
   assign bundle.status  = status;
   assign push           = accept && ((nemit != 9'd0) || last_byte);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_SEARCH;
         cand_ff  <= CAND_W'(1);
         esc_ff   <= ESC_NONE;
         pend_ff  <= '0;
         count_ff <= '0;
         trunc_ff <= 1'b0;
      end else if (accept) begin
         phase_ff <= phase_in;
         cand_ff  <= cand_in;
         esc_ff   <= esc_in;
         pend_ff  <= pend_in;
         count_ff <= count_in;
         trunc_ff <= trunc_in;
      end
   end

endmodule

@@ sv/qpx_queue.sv @@
`timescale 1ns / 1ps
// Small bundle queue between the front and back parts.
module qpx_queue import qpx_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  bundle_type wr_data,
   input  logic       pop,
   output bundle_type rd_data,
   output logic       full,
   output logic       empty
);

   bundle_type         entry_ff [QDEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]  count_ff, count_in;

   assign full    = (count_ff == QCNT_W'(QDEPTH));
   assign empty   = (count_ff == '0);
   assign rd_data = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_ff + QPTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_ff + QPTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

@@ sv/qpx_back.sv @@
`timescale 1ns / 1ps
// Back part: unpacks bundles into single result transactions behind an output register.
module qpx_back import qpx_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  bundle_type q_data,
   input  logic       q_empty,
   output logic       q_pop,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_out_kind,
   output logic [7:0] rsp_out_byte,
   output logic [1:0] rsp_result_status,
   output logic       rsp_run_end
);

   bundle_type cur_ff, cur_in;
   logic       cur_valid_ff, cur_valid_in;
   logic [1:0] pos_ff, pos_in;

   logic       out_valid_ff, out_valid_in;
   logic       out_kind_ff, out_kind_in;
   logic [7:0] out_byte_ff, out_byte_in;
   logic [1:0] out_status_ff, out_status_in;
   logic       out_end_ff, out_end_in;

   logic       load;
   logic       is_final;
   logic [2:0] total;
   logic [7:0] sel_byte;

   assign total    = 3'(cur_ff.nbytes) + 3'(cur_ff.stat_en);
   assign is_final = ((3'(pos_ff) + 3'd1) == total);
   assign load     = cur_valid_ff && (!out_valid_ff || rsp_ready);
   assign q_pop    = !q_empty && (!cur_valid_ff || (load && is_final));

   always_comb begin
      case (pos_ff)
         2'd0:    sel_byte = cur_ff.data[0];
         2'd1:    sel_byte = cur_ff.data[1];
         2'd2:    sel_byte = cur_ff.data[2];
         default: sel_byte = '0;
      endcase
   end

   always_comb begin
      cur_in       = cur_ff;
      cur_valid_in = cur_valid_ff;
      pos_in       = pos_ff;
      if (q_pop) begin
         cur_in       = q_data;
         cur_valid_in = 1'b1;
         pos_in       = '0;
      end else if (load && is_final) begin
         cur_valid_in = 1'b0;
      end else if (load) begin
         pos_in = pos_ff + 2'd1;
      end

      out_valid_in  = out_valid_ff;
      out_kind_in   = out_kind_ff;
      out_byte_in   = out_byte_ff;
      out_status_in = out_status_ff;
      out_end_in    = out_end_ff;
      if (load) begin
         out_valid_in = 1'b1;
         out_end_in   = is_final;
         if (pos_ff < cur_ff.nbytes) begin
            out_kind_in   = KIND_BYTE;
            out_byte_in   = sel_byte;
            out_status_in = ST_COMPLETE;
         end else begin
            out_kind_in   = KIND_STATUS;
            out_byte_in   = '0;
            out_status_in = cur_ff.status;
         end
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
         pos_ff       <= '0;
      end else begin
         cur_valid_ff <= cur_valid_in;
         out_valid_ff <= out_valid_in;
         pos_ff       <= pos_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff        <= cur_in;
      out_kind_ff   <= out_kind_in;
      out_byte_ff   <= out_byte_in;
      out_status_ff <= out_status_in;
      out_end_ff    <= out_end_in;
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_out_kind      = out_kind_ff;
   assign rsp_out_byte      = out_byte_ff;
   assign rsp_result_status = out_status_ff;
   assign rsp_run_end       = out_end_ff;

endmodule

@@ sv/qpx_checker.sv @@
`timescale 1ns / 1ps
// Port-level checker for the query parameter block, bound to the top level.
module qpx_checker import qpx_pkg::*; (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic       rsp_out_kind,
   input logic [7:0] rsp_out_byte,
   input logic [1:0] rsp_result_status,
   input logic       rsp_run_end
);

   // a stalled result transaction holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_kind) &&
      $stable(rsp_out_byte) && $stable(rsp_result_status) && $stable(rsp_run_end))
      else $error("rsp transaction changed while stalled");

   // status is always the final result of its input byte
   a_status_ends_run: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_out_kind == KIND_STATUS |-> rsp_run_end)
      else $error("status transaction without run_end");

   // byte transactions carry a zero status field
   a_byte_status_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_out_kind == KIND_BYTE |-> rsp_result_status == ST_COMPLETE)
      else $error("byte transaction with nonzero status");

   // status transaction carries a zero byte
   a_status_byte_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_out_kind == KIND_STATUS |-> rsp_out_byte == 8'd0)
      else $error("status transaction with nonzero byte");

   // output empties out of reset
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp_valid high after reset");

endmodule

bind query_parameter_extract_decode qpx_checker u_qpx_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_valid),
   .rsp_ready         (rsp_ready),
   .rsp_out_kind      (rsp_out_kind),
   .rsp_out_byte      (rsp_out_byte),
   .rsp_result_status (rsp_result_status),
   .rsp_run_end       (rsp_run_end)
);

@@ bench/tb.sv @@
`timescale 1ns / 1ps
// Self-checking bench for query_parameter_extract_decode: query buffers in, decoded value bytes and status out.

import qpx_pkg::*;

typedef struct packed {
   logic       kind;
   logic [7:0] data;
   logic [1:0] status;
   logic       run_end;
} rsp_item_type;

typedef enum logic [1:0] {SEEK_NAME, IN_VALUE, PAST_VALUE} scan_phase_type;
typedef enum logic [1:0] {ESC_IDLE, ESC_PERCENT, ESC_ONE_DIGIT} escape_type;

// Tracks the register copy and scan state; predicts the results of each accepted byte.
class qpx_scoreboard;
   logic [63:0] name_text;
   logic [3:0]  name_length;
   logic        plus_as_space;
   logic [8:0]  output_capacity;

   scan_phase_type    phase;
   logic [MAX_NAME:0] live_starts;
   escape_type        esc;
   logic [7:0]        held_digit;
   int unsigned       value_count;
   bit                dropped;

   rsp_item_type burst[$];
   rsp_item_type awaited[$];
   int unsigned  failures;
   int unsigned  bytes_noted;
   int unsigned  value_bytes;
   int unsigned  status_count[3];

   function new();
      name_text       = '0;
      name_length     = '0;
      plus_as_space   = 1'b0;
      output_capacity = 9'd256;
      failures        = 0;
      bytes_noted     = 0;
      value_bytes     = 0;
      status_count    = '{0, 0, 0};
      clear_scan();
   endfunction

   function void clear_scan();
      phase       = SEEK_NAME;
      live_starts = CAND_W'(1);
      esc         = ESC_IDLE;
      held_digit  = '0;
      value_count = 0;
      dropped     = 1'b0;
   endfunction

   function void write_reg(logic [1:0] idx, logic [63:0] v);
      case (idx)
         CSR_NAME_TEXT:     name_text       = v;
         CSR_NAME_LENGTH:   name_length     = v[3:0];
         CSR_PLUS_AS_SPACE: plus_as_space   = v[0];
         CSR_OUTPUT_CAP:    output_capacity = v[8:0];
         default: ;
      endcase
   endfunction

   function rsp_item_type make_item(logic kind, logic [7:0] data, logic [1:0] status);
      rsp_item_type it;
      it.kind    = kind;
      it.data    = data;
      it.status  = status;
      it.run_end = 1'b0;
      return it;
   endfunction

   // -1 for anything that is not a hex digit
   function int digit_value(logic [7:0] c);
      if (c >= "0" && c <= "9") return c - "0";
      if (c >= "a" && c <= "f") return c - "a" + 10;
      if (c >= "A" && c <= "F") return c - "A" + 10;
      return -1;
   endfunction

   function void push_byte(logic [7:0] d);
      int unsigned room;
      room = (output_capacity == 0) ? 1 :
             (output_capacity > MAX_OUTPUT) ? MAX_OUTPUT : output_capacity;
      if (value_count < room - 1) begin
         burst.push_back(make_item(KIND_BYTE, d, ST_COMPLETE));
         value_count++;
      end else begin
         dropped = 1'b1;
      end
   endfunction

   // held '%' or '%H' goes out literally
   function void flush_escape();
      if (esc != ESC_IDLE) push_byte(CH_PCT);
      if (esc == ESC_ONE_DIGIT) push_byte(held_digit);
      esc = ESC_IDLE;
   endfunction

   function void value_char(logic [7:0] b);
      if (esc == ESC_PERCENT) begin
         if (digit_value(b) >= 0) begin
            held_digit = b;
            esc        = ESC_ONE_DIGIT;
            return;
         end
         flush_escape();
      end else if (esc == ESC_ONE_DIGIT) begin
         if (digit_value(b) >= 0) begin
            push_byte(8'((digit_value(held_digit) << 4) | digit_value(b)));
            esc = ESC_IDLE;
            return;
         end
         flush_escape();
      end
      if (b == CH_PCT) esc = ESC_PERCENT;
      else if (plus_as_space && b == CH_PLUS) push_byte(CH_SPACE);
      else push_byte(b);
   endfunction

   // all overlapping segment starts advance together; any full match plus '=' wins
   function void seek_char(logic [7:0] b);
      int                len;
      int                k;
      logic [MAX_NAME:0] nxt;
      bit                hit;
      len = (name_length > MAX_NAME) ? MAX_NAME : name_length;
      nxt = '0;
      hit = 1'b0;
      for (k = 0; k <= len; k++) begin
         if (live_starts[k]) begin
            if (k < len) begin
               if (b == name_text[8*k +: 8]) nxt[k+1] = 1'b1;
            end else if (b == CH_EQ) begin
               hit = 1'b1;
            end
         end
      end
      if (hit) begin
         phase       = IN_VALUE;
         live_starts = '0;
      end else begin
         live_starts = nxt | CAND_W'(b == CH_AMP);
      end
   endfunction

   function void note_input(logic [7:0] b, logic last);
      rsp_item_type tail;
      logic [1:0]   st;
      bytes_noted++;
      burst.delete();
      case (phase)
         SEEK_NAME: seek_char(b);
         IN_VALUE: begin
            if (b == CH_AMP) begin
               flush_escape();
               phase = PAST_VALUE;
            end else begin
               value_char(b);
            end
         end
         default: ;
      endcase
      if (last) begin
         if (phase == IN_VALUE) flush_escape();
         st = (phase == SEEK_NAME) ? ST_NOT_FOUND : (dropped ? ST_TRUNCATED : ST_COMPLETE);
         burst.push_back(make_item(KIND_STATUS, 8'h00, st));
         clear_scan();
      end
      if (burst.size() > 0) begin
         tail         = burst.pop_back();
         tail.run_end = 1'b1;
         burst.push_back(tail);
      end
      foreach (burst[i]) awaited.push_back(burst[i]);
   endfunction

   function void compare_field(string field, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected %0h, actual %0h", field, want, got);
         failures++;
      end
   endfunction

   function void check_result(logic kind, logic [7:0] data, logic [1:0] status,
                              logic run_end);
      rsp_item_type want;
      if (awaited.size() == 0) begin
         $error("result with nothing pending: kind %0h byte %0h status %0h end %0h",
                kind, data, status, run_end);
         failures++;
         return;
      end
      want = awaited.pop_front();
      compare_field("out_kind", want.kind, kind);
      compare_field("out_byte", want.data, data);
      compare_field("result_status", want.status, status);
      compare_field("run_end", want.run_end, run_end);
      if (want.kind == KIND_BYTE) value_bytes++;
      else if (want.status <= ST_NOT_FOUND) status_count[want.status]++;
   endfunction
endclass

module tb;
   localparam int RANDOM_PHASES     = 9;
   localparam int ITEMS_PER_PHASE   = 26;
   localparam int DRAIN_SETTLE      = 8;    // bundle queue plus output stage, with slack
   localparam int RSP_HOLD_CYCLES   = 150;  // long receiver stall to back up the input

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [7:0]  req_in_byte;
   logic        req_last_byte;
   logic        rsp_valid;
   logic        rsp_ready;
   logic        rsp_out_kind;
   logic [7:0]  rsp_out_byte;
   logic [1:0]  rsp_result_status;
   logic        rsp_run_end;
   logic        csr_write_enable;
   logic [1:0]  csr_index;
   logic [63:0] csr_wdata;

   qpx_scoreboard sb = new();

   // current query buffer under construction
   logic [7:0]  query_text[$];
   int unsigned send_idle_pct = 0;
   int unsigned recv_idle_pct = 0;
   bit          hold_request  = 1'b0;
   int unsigned settings_count = 0;

   query_parameter_extract_decode dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_in_byte       (req_in_byte),
      .req_last_byte     (req_last_byte),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_out_kind      (rsp_out_kind),
      .rsp_out_byte      (rsp_out_byte),
      .rsp_result_status (rsp_result_status),
      .rsp_run_end       (rsp_run_end),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   always #2 clock = ~clock;

   // Every accepted result transaction goes to the scoreboard, sampled at the rising edge.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         sb.check_result(rsp_out_kind, rsp_out_byte, rsp_result_status, rsp_run_end);
      end
   end

   // Receiver: random backpressure, plus one long hold-off on request.
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            rsp_ready <= 1'b0;
            repeat (RSP_HOLD_CYCLES) @(negedge clock);
            hold_request = 1'b0;
         end
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Watchdog: far beyond the slowest legal run.
   initial begin
      #2_000_000;
      $display("timeout: results still pending = %0d", sb.awaited.size());
      $display("Simulation FAILED");
      $finish;
   end

   // One byte transaction. Valid stays up after acceptance until the next falling edge,
   // where it either carries the next byte or is dropped by an idle roll / drain.
   task automatic send_byte(input logic [7:0] b, input logic last);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_in_byte   <= b;
      req_last_byte <= last;
      do @(posedge clock); while (!req_ready);
      sb.note_input(b, last);
   endtask

   task automatic send_query();
      foreach (query_text[i]) send_byte(query_text[i], i == query_text.size() - 1);
   endtask

   task automatic send_text(input string s);
      int i;
      query_text.delete();
      for (i = 0; i < s.len(); i++) query_text.push_back(s[i]);
      send_query();
   endtask

   // Stop offering, then wait until every predicted result has come back.
   task automatic wait_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (sb.awaited.size() != 0) @(posedge clock);
      repeat (DRAIN_SETTLE) @(posedge clock);
   endtask

   task automatic write_csr(input logic [1:0] idx, input logic [63:0] val);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_wdata        <= val;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      sb.write_reg(idx, val);
   endtask

   // Registers only change with the block idle. Upper wdata bits are junk on purpose.
   task automatic program_regs(input logic [63:0] text, input logic [3:0] len,
                               input logic plus, input logic [8:0] cap);
      wait_drained();
      write_csr(CSR_NAME_TEXT, text);
      write_csr(CSR_NAME_LENGTH, {$urandom(), 28'($urandom()), len});
      write_csr(CSR_PLUS_AS_SPACE, {$urandom(), 31'($urandom()), plus});
      write_csr(CSR_OUTPUT_CAP, {$urandom(), 23'($urandom()), cap});
      settings_count++;
   endtask

   function automatic logic [63:0] pack_name(input string s);
      logic [63:0] v;
      int          k;
      v = {$urandom(), $urandom()};
      for (k = 0; k < s.len(); k++) v[8*k +: 8] = s[k];
      return v;
   endfunction

   // Small alphabets make overlapping partial matches likely; phase 5 puts '&' and '='
   // inside the name, the last phase leaves the name bytes fully random.
   function automatic logic [63:0] random_name(input int p);
      logic [63:0] v;
      string       pool;
      int          k;
      v    = {$urandom(), $urandom()};
      pool = (p == 5) ? "a&=" : "abxyz";
      if (p != RANDOM_PHASES - 1) begin
         for (k = 0; k < MAX_NAME; k++) v[8*k +: 8] = pool[$urandom_range(pool.len() - 1)];
      end
      return v;
   endfunction

   function automatic int name_chars();
      return (sb.name_length > MAX_NAME) ? MAX_NAME : sb.name_length;
   endfunction

   function automatic void append_name(input int n);
      int k;
      for (k = 0; k < n; k++) query_text.push_back(sb.name_text[8*k +: 8]);
   endfunction

   // Hex digits and '%' are common so full, partial and broken escapes all show up.
   function automatic logic [7:0] rand_value_char();
      string hexes;
      hexes = "0123456789abcdefABCDEF";
      case ($urandom_range(9))
         0, 1, 2, 3: return hexes[$urandom_range(hexes.len() - 1)];
         4:          return CH_PCT;
         5:          return CH_PLUS;
         6:          return 8'($urandom_range(255));
         default:    return 8'($urandom_range("z", "g"));
      endcase
   endfunction

   // Mostly well-formed queries (target, prefix, near-miss and foreign names, random
   // values); a quarter are raw noise.
   task automatic build_query();
      int    nseg, seg, vlen, n;
      string noise_pool;
      noise_pool = "&=%+ab";
      query_text.delete();
      if ($urandom_range(99) < 25) begin
         n = $urandom_range(12, 1);
         repeat (n) begin
            if ($urandom_range(2) == 0) query_text.push_back(8'($urandom_range(255)));
            else query_text.push_back(noise_pool[$urandom_range(noise_pool.len() - 1)]);
         end
      end else begin
         nseg = $urandom_range(4, 1);
         for (seg = 0; seg < nseg; seg++) begin
            if (seg > 0 || $urandom_range(9) == 0) query_text.push_back(CH_AMP);
            case ($urandom_range(5))
               0, 1, 2: append_name(name_chars());
               3:       append_name($urandom_range(name_chars()));
               4:       repeat ($urandom_range(4, 1))
                           query_text.push_back(8'("a" + $urandom_range(3)));
               default: begin
                  append_name(name_chars());
                  query_text.push_back(8'("a" + $urandom_range(25)));
               end
            endcase
            if ($urandom_range(9) != 0) query_text.push_back(CH_EQ);
            vlen = $urandom_range(10);
            repeat (vlen) query_text.push_back(rand_value_char());
         end
      end
      if (query_text.size() == 0) query_text.push_back("x");
   endtask

   initial begin
      int          p;
      int unsigned phase_items;
      logic [3:0]  len;
      logic        plus;
      logic [8:0]  cap;

      reset            = 1'b1;
      req_valid        = 1'b0;
      req_in_byte      = '0;
      req_last_byte    = 1'b0;
      csr_write_enable = 1'b0;
      csr_index        = CSR_NAME_TEXT;
      csr_wdata        = '0;
      repeat (3) @(negedge clock);
      reset <= 1'b0;

      // ---- directed ----
      // escape with a non-hex second digit, form-mode plus, lone '%' held at the end
      program_regs(pack_name("id"), 4'd2, 1'b1, 9'd256);
      send_text("x&id=%4g+%");
      // single all-ones byte: nothing found
      query_text = '{8'hff};
      send_query();

      // empty name matches the first '='; byte extremes in the value; tail after '&' ignored
      program_regs(pack_name(""), 4'd0, 1'b0, 9'd256);
      query_text = '{CH_EQ, 8'h00, 8'hff, CH_PCT, "7", "e", CH_AMP, "z"};
      send_query();

      // capacity zero acts as one: everything dropped
      program_regs(pack_name(""), 4'd0, 1'b0, 9'd0);
      send_text("=ab");
      // value exactly fills the room: complete, not truncated
      program_regs(pack_name(""), 4'd0, 1'b0, 9'd3);
      send_text("=ab");

      // ---- random phases: busy/idle mixes, then none ----
      for (p = 0; p < RANDOM_PHASES; p++) begin
         case (p)
            0: begin len = 4'd0;  plus = 1'b0; cap = 9'd1;   end
            1: begin len = 4'd8;  plus = 1'b1; cap = 9'd256; end
            2: begin len = 4'd15; plus = 1'b0; cap = 9'd0;   end   // overlong name
            3: begin len = 4'd3;  plus = 1'b1; cap = 9'd511; end   // capacity clipped
            4: begin
               len  = 4'($urandom_range(8, 1));
               plus = 1'($urandom);
               cap  = 9'($urandom_range(6, 2));
            end
            5: begin len = 4'd2;  plus = 1'b1; cap = 9'($urandom_range(8, 3)); end
            6: begin len = 4'($urandom_range(4, 1)); plus = 1'($urandom); cap = 9'd256; end
            default: begin
               len  = 4'($urandom_range(15));
               plus = 1'($urandom);
               cap  = 9'($urandom_range(511));
            end
         endcase
         program_regs(random_name(p), len, plus, cap);

         if (p < 3) begin
            send_idle_pct = 32;
            recv_idle_pct = 62;
         end else if (p < 6) begin
            send_idle_pct = 62;
            recv_idle_pct = 32;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end

         phase_items = 0;
         if (p == 6) begin
            // receiver stalls while a long matching value streams in at full rate
            hold_request = 1'b1;
            query_text.delete();
            append_name(name_chars());
            query_text.push_back(CH_EQ);
            repeat (24) query_text.push_back(8'("a" + $urandom_range(25)));
            send_query();
            phase_items += query_text.size();
         end
         while (phase_items < ITEMS_PER_PHASE) begin
            build_query();
            send_query();
            phase_items += query_text.size();
         end
      end

      wait_drained();
      $display("covered %0d query bytes over %0d register settings, idle mixes and a long stall",
               sb.bytes_noted, settings_count);
      $display("checked %0d value bytes; status complete %0d, truncated %0d, not found %0d",
               sb.value_bytes, sb.status_count[ST_COMPLETE], sb.status_count[ST_TRUNCATED],
               sb.status_count[ST_NOT_FOUND]);
      if (sb.failures == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end
endmodule

@@ files.f @@
sv/qpx_pkg.sv
sv/qpx_front.sv
sv/qpx_queue.sv
sv/qpx_back.sv
sv/query_parameter_extract_decode.sv
sv/qpx_checker.sv
bench/tb.sv
